FILE: rtl/fac_pkg.sv
package fac_pkg;

	localparam int MAX_SEG = 64;
	localparam int IDX_W = $clog2(MAX_SEG);
	localparam int CNT_W = IDX_W + 1;
	localparam int ADDR_W = 16;
	localparam int HDL_W = 16;
	localparam int STAT_W = 32;
	localparam logic [HDL_W-1:0] HANDLE_MAX = '1;
	localparam logic [STAT_W-1:0] STAT_MAX = '1;

	// one table entry
	typedef struct packed {
		logic              free;
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] size;
		logic [HDL_W-1:0]  handle;
	} seg_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_RIGHT,
		CELL_LEFT,
		CELL_LOAD
	} cell_mode_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_NO_FIT,
		ST_NOT_FOUND,
		ST_FULL
	} status_t;

	typedef enum logic [1:0] {
		POL_FIRST,
		POL_BEST,
		POL_WORST,
		POL_SPARE
	} policy_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_APPLY,
		S_SHIFT,
		S_STAT,
		S_DONE
	} fsm_t;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;
	localparam logic REG_FIT_POLICY = 1'b0;
	localparam logic REG_TOTAL_SIZE = 1'b1;

endpackage

FILE: rtl/fac_cell.sv
module fac_cell
	import fac_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  seg_t       rst_val,
	input  cell_mode_t mode,
	input  seg_t       left,
	input  seg_t       right,
	input  seg_t       load,
	output seg_t       q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= rst_val;
		end else begin
			case (mode)
				CELL_RIGHT: q <= right;
				CELL_LEFT:  q <= left;
				CELL_LOAD:  q <= load;
				default:    q <= q;
			endcase
		end
	end

endmodule

FILE: rtl/free_list_fit_allocator.sv
// free_list_fit_allocator: segment allocator over an address-ordered table
// cmd channel: cmd, request_size, release_handle; a transfer happens when
//   cmd_valid is high and cmd_stall is low; cmd_stall is high while a
//   command is in work
// rsp channel: status, new_handle, block_start, free_total, largest_free
//   and the three counters; a transfer happens when rsp_valid is high and
//   rsp_stall is low
// cfg channel: cfg_index 0 selects fit_policy, 1 selects total_size; a
//   total_size write rebuilds the table as one free segment
// the table is a row of 64 cells; every command takes one full rotation of
//   the row to search, one update of the cells, a left shift for each
//   merged neighbour of a freed segment, and one more rotation to sum the
//   free space
// one command in work at a time; a new command is taken as soon as the
//   result sits in the output register, even if the receiver stalls it
// when the receiver stalls and the next result is ready, the block waits
// reset leaves one free segment of 65535 units at address 0, policy first
//   fit, counters and handle at zero
module free_list_fit_allocator
	import fac_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  logic                cmd,
	input  logic [ADDR_W-1:0]   request_size,
	input  logic [HDL_W-1:0]    release_handle,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [1:0]          status,
	output logic [HDL_W-1:0]    new_handle,
	output logic [ADDR_W-1:0]   block_start,
	output logic [ADDR_W-1:0]   free_total,
	output logic [ADDR_W-1:0]   largest_free,
	output logic [STAT_W-1:0]   alloc_count,
	output logic [STAT_W-1:0]   release_count,
	output logic [STAT_W-1:0]   failure_count,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data
);

	fsm_t state_q, state_nxt;

	seg_t cells [MAX_SEG];
	cell_mode_t mode [MAX_SEG];
	seg_t load [MAX_SEG];

	logic [IDX_W-1:0] k_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       policy_q;
	logic             cmd_q;
	logic [ADDR_W-1:0] req_q;
	logic [HDL_W-1:0] hdl_q;

	// search results
	logic             found_q;
	logic [IDX_W-1:0] p_q;
	logic [ADDR_W-1:0] psz_q, pstart_q;
	logic             trk_free_q;
	logic [ADDR_W-1:0] trk_size_q, trk_start_q;
	logic             pf_q, nf_q, nextcap_q;
	logic [ADDR_W-1:0] prevsize_q, prevstart_q, nsize_q;
	logic [1:0]       shifts_q;

	logic [HDL_W-1:0] last_hdl_q;
	logic [STAT_W-1:0] allocs_q, frees_q, fails_q;
	logic [ADDR_W-1:0] ftot_q, flarge_q;
	logic [1:0]       res_status_q;
	logic [HDL_W-1:0] res_hdl_q;
	logic [ADDR_W-1:0] res_start_q;

	logic rsp_valid_q;
	logic [1:0] status_q;
	logic [HDL_W-1:0] new_handle_q;
	logic [ADDR_W-1:0] block_start_q, free_total_q, largest_free_q;
	logic [STAT_W-1:0] alloc_count_q, release_count_q, failure_count_q;

	seg_t e;
	logic ev, last_k, rotating, cmd_acc, cfg_wr, out_load;
	logic fit, take, match;
	logic rem_nz, alloc_ok;
	logic [ADDR_W-1:0] rem;
	logic [HDL_W-1:0] next_hdl;
	logic [IDX_W-1:0] j_w;
	logic [ADDR_W-1:0] msize;
	logic [1:0] r_w;
	seg_t ent_a, ent_b, ent_m, ent_init, rst0, right63;

	assign e = cells[0];
	assign ev = {1'b0, k_q} < cnt_q;
	assign last_k = k_q == IDX_W'(MAX_SEG - 1);
	assign rotating = (state_q == S_SCAN) || (state_q == S_STAT);
	assign cmd_stall = state_q != S_IDLE;
	assign cmd_acc = cmd_valid && !cmd_stall;
	assign cfg_ready = state_q == S_IDLE;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign out_load = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	// search compare on the entry passing cell 0
	assign fit = ev && e.free && (e.size >= req_q) && (req_q != '0);
	always_comb begin
		case (policy_t'(policy_q))
			POL_BEST:  take = fit && (!found_q || e.size < psz_q);
			POL_WORST: take = fit && (!found_q || e.size > psz_q);
			default:   take = fit && !found_q;
		endcase
	end
	assign match = ev && !e.free && (e.handle == hdl_q) && (hdl_q != '0) && !found_q;

	// split and merge arithmetic
	assign rem = psz_q - req_q;
	assign rem_nz = rem != '0;
	assign alloc_ok = found_q && !(rem_nz && cnt_q == CNT_W'(MAX_SEG));
	assign next_hdl = (last_hdl_q == HANDLE_MAX) ? HDL_W'(1) : last_hdl_q + HDL_W'(1);
	assign j_w = pf_q ? p_q - IDX_W'(1) : p_q;
	assign msize = (pf_q ? prevsize_q : '0) + psz_q + (nf_q ? nsize_q : '0);
	assign r_w = {1'b0, pf_q} + {1'b0, nf_q};

	assign ent_a = '{free: 1'b0, start: pstart_q, size: req_q, handle: next_hdl};
	assign ent_b = '{free: 1'b1, start: pstart_q + req_q, size: rem, handle: '0};
	assign ent_m = '{free: 1'b1, start: pf_q ? prevstart_q : pstart_q, size: msize,
		handle: '0};
	assign ent_init = '{free: 1'b1, start: '0, size: cfg_data[ADDR_W-1:0], handle: '0};
	assign rst0 = '{free: 1'b1, start: '0, size: '1, handle: '0};
	assign right63 = rotating ? cells[0] : '0;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE:  if (cmd_acc) state_nxt = S_SCAN;
			S_SCAN:  if (last_k) state_nxt = S_APPLY;
			S_APPLY: begin
				if (cmd_q == CMD_FREE && found_q && r_w != 2'd0) begin
					state_nxt = S_SHIFT;
				end else begin
					state_nxt = S_STAT;
				end
			end
			S_SHIFT: if (shifts_q == 2'd1) state_nxt = S_STAT;
			S_STAT:  if (last_k) state_nxt = S_DONE;
			S_DONE:  if (out_load) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	// cell controls
	for (genvar k = 0; k < MAX_SEG; k++) begin : g_ctl
		localparam logic [IDX_W-1:0] KK = IDX_W'(k);
		always_comb begin
			mode[k] = CELL_HOLD;
			load[k] = '0;
			case (state_q)
				S_IDLE: begin
					if (cfg_wr && cfg_index == REG_TOTAL_SIZE) begin
						mode[k] = CELL_LOAD;
						load[k] = (k == 0) ? ent_init : '0;
					end
				end
				S_SCAN, S_STAT: mode[k] = CELL_RIGHT;
				S_APPLY: begin
					if (cmd_q == CMD_ALLOC) begin
						if (alloc_ok) begin
							if (KK == p_q) begin
								mode[k] = CELL_LOAD;
								load[k] = ent_a;
							end else if (rem_nz && KK == p_q + IDX_W'(1)) begin
								mode[k] = CELL_LOAD;
								load[k] = ent_b;
							end else if (rem_nz && KK > p_q + IDX_W'(1)) begin
								mode[k] = CELL_LEFT;
							end
						end
					end else if (found_q && KK == j_w) begin
						mode[k] = CELL_LOAD;
						load[k] = ent_m;
					end
				end
				S_SHIFT: if (KK > j_w) mode[k] = CELL_RIGHT;
				default: mode[k] = CELL_HOLD;
			endcase
		end

		fac_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.rst_val ((k == 0) ? rst0 : '0),
			.mode    (mode[k]),
			.left    ((k == 0) ? '0 : cells[(k + MAX_SEG - 1) % MAX_SEG]),
			.right   ((k == MAX_SEG - 1) ? right63 : cells[(k + 1) % MAX_SEG]),
			.load    (load[k]),
			.q       (cells[k])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q <= '0;
			cnt_q <= CNT_W'(1);
			policy_q <= POL_FIRST;
			last_hdl_q <= '0;
			allocs_q <= '0;
			frees_q <= '0;
			fails_q <= '0;
			rsp_valid_q <= 1'b0;
			found_q <= 1'b0;
			nextcap_q <= 1'b0;
			shifts_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wr) begin
				if (cfg_index == REG_FIT_POLICY) begin
					policy_q <= cfg_data[1:0];
				end else begin
					cnt_q <= CNT_W'(1);
				end
			end
			if (rotating) begin
				k_q <= k_q + IDX_W'(1);
			end else begin
				k_q <= '0;
			end
			if (cmd_acc) begin
				found_q <= 1'b0;
				nextcap_q <= 1'b0;
			end
			if (state_q == S_SCAN) begin
				if (cmd_q == CMD_ALLOC) begin
					if (take) found_q <= 1'b1;
				end else begin
					if (match) found_q <= 1'b1;
					nextcap_q <= match;
				end
			end
			if (state_q == S_APPLY) begin
				shifts_q <= r_w;
				if (cmd_q == CMD_ALLOC) begin
					if (alloc_ok) begin
						last_hdl_q <= next_hdl;
						allocs_q <= (allocs_q == STAT_MAX) ? allocs_q : allocs_q + 1'b1;
						if (rem_nz) cnt_q <= cnt_q + CNT_W'(1);
					end else begin
						fails_q <= (fails_q == STAT_MAX) ? fails_q : fails_q + 1'b1;
					end
				end else if (found_q) begin
					frees_q <= (frees_q == STAT_MAX) ? frees_q : frees_q + 1'b1;
					cnt_q <= cnt_q - CNT_W'(r_w);
				end
			end
			if (state_q == S_SHIFT) shifts_q <= shifts_q - 2'd1;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			cmd_q <= cmd;
			req_q <= request_size;
			hdl_q <= release_handle;
			trk_free_q <= 1'b0;
			pf_q <= 1'b0;
			nf_q <= 1'b0;
		end
		if (state_q == S_SCAN) begin
			trk_free_q <= ev && e.free;
			trk_size_q <= e.size;
			trk_start_q <= e.start;
			if ((cmd_q == CMD_ALLOC && take) || (cmd_q == CMD_FREE && match)) begin
				p_q <= k_q;
				psz_q <= e.size;
				pstart_q <= e.start;
				pf_q <= trk_free_q;
				prevsize_q <= trk_size_q;
				prevstart_q <= trk_start_q;
			end
			if (nextcap_q) begin
				nf_q <= ev && e.free;
				nsize_q <= e.size;
			end
		end
		if (state_q == S_APPLY) begin
			ftot_q <= '0;
			flarge_q <= '0;
			res_hdl_q <= '0;
			res_start_q <= '0;
			if (cmd_q == CMD_ALLOC) begin
				if (!found_q) begin
					res_status_q <= ST_NO_FIT;
				end else if (!alloc_ok) begin
					res_status_q <= ST_FULL;
				end else begin
					res_status_q <= ST_OK;
					res_hdl_q <= next_hdl;
					res_start_q <= pstart_q;
				end
			end else begin
				res_status_q <= found_q ? ST_OK : ST_NOT_FOUND;
			end
		end
		if (state_q == S_STAT && ev && e.free) begin
			ftot_q <= ftot_q + e.size;
			if (e.size > flarge_q) flarge_q <= e.size;
		end
		if (out_load) begin
			status_q <= res_status_q;
			new_handle_q <= res_hdl_q;
			block_start_q <= res_start_q;
			free_total_q <= ftot_q;
			largest_free_q <= flarge_q;
			alloc_count_q <= allocs_q;
			release_count_q <= frees_q;
			failure_count_q <= fails_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status = status_q;
	assign new_handle = new_handle_q;
	assign block_start = block_start_q;
	assign free_total = free_total_q;
	assign largest_free = largest_free_q;
	assign alloc_count = alloc_count_q;
	assign release_count = release_count_q;
	assign failure_count = failure_count_q;

	// table never empty and never over capacity
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 && cnt_q <= CNT_W'(MAX_SEG))
		else $error("segment count out of range");

	// an update grows the table by at most one entry
	a_cnt_grow: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_APPLY |=> cnt_q <= $past(cnt_q) + CNT_W'(1))
		else $error("table grew by more than one entry");

	// merge shifts only follow a free
	a_shift_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |-> cmd_q == CMD_FREE && found_q)
		else $error("shift without a free");

endmodule

FILE: dv/free_list_fit_allocator_tb.sv
module free_list_fit_allocator_tb;
	import fac_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 200;

	// one result as the block reports it
	typedef struct packed {
		status_t           status;
		logic [HDL_W-1:0]  handle;
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] free_sum;
		logic [ADDR_W-1:0] free_max;
		logic [STAT_W-1:0] n_alloc;
		logic [STAT_W-1:0] n_release;
		logic [STAT_W-1:0] n_fail;
	} alloc_rsp_t;

	// directed stimulus row; typed rows carry status, handle and start
	typedef struct packed {
		logic              op;
		logic [ADDR_W-1:0] size;
		logic [HDL_W-1:0]  hdl;
		logic              typed;
		status_t           st;
		logic [HDL_W-1:0]  h;
		logic [ADDR_W-1:0] s;
	} cmd_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cmd_valid = 1'b0;
	logic                cmd_stall;
	logic                cmd = CMD_ALLOC;
	logic [ADDR_W-1:0]   request_size = '0;
	logic [HDL_W-1:0]    release_handle = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	logic [1:0]          status;
	logic [HDL_W-1:0]    new_handle;
	logic [ADDR_W-1:0]   block_start;
	logic [ADDR_W-1:0]   free_total;
	logic [ADDR_W-1:0]   largest_free;
	logic [STAT_W-1:0]   alloc_count;
	logic [STAT_W-1:0]   release_count;
	logic [STAT_W-1:0]   failure_count;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic                cfg_index = REG_FIT_POLICY;
	logic [15:0]         cfg_data = '0;

	free_list_fit_allocator i_dut (.*);

	always #5 clk = ~clk;

	// shadow segment table of the allocator
	logic [ADDR_W-1:0] tbl_start [MAX_SEG];
	logic [ADDR_W-1:0] tbl_size [MAX_SEG];
	logic [HDL_W-1:0]  tbl_handle [MAX_SEG];
	logic              tbl_free [MAX_SEG];
	int                tbl_count;
	logic [HDL_W-1:0]  handle_ctr;
	logic [STAT_W-1:0] allocs_ok, releases_ok, allocs_bad;
	policy_t           cur_policy;
	logic [ADDR_W-1:0] region_size;

	alloc_rsp_t        pending_rsp[$];
	logic [HDL_W-1:0]  live_handles[$];
	int                mismatches = 0;
	int                cycles = 0;
	bit                quiet = 0;

	function automatic logic [STAT_W-1:0] sat_up(logic [STAT_W-1:0] v);
		return (v == STAT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic void rebuild_region();
		for (int i = 0; i < MAX_SEG; i++) begin
			tbl_start[i] = '0;
			tbl_size[i] = '0;
			tbl_handle[i] = '0;
			tbl_free[i] = 1'b0;
		end
		tbl_size[0] = region_size;
		tbl_free[0] = 1'b1;
		tbl_count = 1;
		live_handles.delete();
	endfunction

	function automatic void drop_entry(int idx);
		for (int k = idx; k + 1 < tbl_count; k++) begin
			tbl_start[k] = tbl_start[k+1];
			tbl_size[k] = tbl_size[k+1];
			tbl_handle[k] = tbl_handle[k+1];
			tbl_free[k] = tbl_free[k+1];
		end
		tbl_count--;
	endfunction

	// works out the result of one command and updates the shadow table
	function automatic alloc_rsp_t predict_alloc(logic op, logic [ADDR_W-1:0] req,
			logic [HDL_W-1:0] hdl);
		alloc_rsp_t r;
		int p, i;
		bit found, hit;
		logic [ADDR_W-1:0] rem;
		r = '0;
		p = 0;
		found = 0;
		if (op == CMD_ALLOC) begin
			if (req != 0) begin
				for (i = 0; i < tbl_count && !(found && cur_policy != POL_BEST
						&& cur_policy != POL_WORST); i++) begin
					if (tbl_free[i] && tbl_size[i] >= req) begin
						case (cur_policy)
							POL_BEST: begin
								if (!found || tbl_size[i] < tbl_size[p]) p = i;
							end
							POL_WORST: begin
								if (!found || tbl_size[i] > tbl_size[p]) p = i;
							end
							default: p = i;
						endcase
						found = 1;
					end
				end
			end
			rem = tbl_size[p] - req;
			if (!found) begin
				r.status = ST_NO_FIT;
				allocs_bad = sat_up(allocs_bad);
			end else if (rem != 0 && tbl_count >= MAX_SEG) begin
				r.status = ST_FULL;
				allocs_bad = sat_up(allocs_bad);
			end else begin
				if (rem != 0) begin
					for (int k = tbl_count; k > p + 1; k--) begin
						tbl_start[k] = tbl_start[k-1];
						tbl_size[k] = tbl_size[k-1];
						tbl_handle[k] = tbl_handle[k-1];
						tbl_free[k] = tbl_free[k-1];
					end
					tbl_start[p+1] = tbl_start[p] + req;
					tbl_size[p+1] = rem;
					tbl_handle[p+1] = '0;
					tbl_free[p+1] = 1'b1;
					tbl_count++;
				end
				// handles wrap from the top back to 1, never 0
				handle_ctr = (handle_ctr == HANDLE_MAX) ? HDL_W'(1) : handle_ctr + 1'b1;
				tbl_size[p] = req;
				tbl_free[p] = 1'b0;
				tbl_handle[p] = handle_ctr;
				allocs_ok = sat_up(allocs_ok);
				r.status = ST_OK;
				r.handle = handle_ctr;
				r.start = tbl_start[p];
				live_handles.insert(live_handles.size(), handle_ctr);
			end
		end else begin
			hit = 0;
			if (hdl != 0) begin
				for (i = 0; i < tbl_count && !hit; i++) begin
					if (!tbl_free[i] && tbl_handle[i] == hdl) begin
						hit = 1;
						p = i;
					end
				end
			end
			if (!hit) begin
				r.status = ST_NOT_FOUND;
			end else begin
				tbl_free[p] = 1'b1;
				tbl_handle[p] = '0;
				releases_ok = sat_up(releases_ok);
				if (p > 0 && tbl_free[p-1]) begin
					tbl_size[p-1] = tbl_size[p-1] + tbl_size[p];
					drop_entry(p);
					p--;
				end
				if (p + 1 < tbl_count && tbl_free[p+1]) begin
					tbl_size[p] = tbl_size[p] + tbl_size[p+1];
					drop_entry(p + 1);
				end
				r.status = ST_OK;
				for (i = 0; i < live_handles.size(); i++) begin
					if (live_handles[i] == hdl) begin
						live_handles.delete(i);
						break;
					end
				end
			end
		end
		for (i = 0; i < tbl_count; i++) begin
			if (tbl_free[i]) begin
				r.free_sum += tbl_size[i];
				if (tbl_size[i] > r.free_max) r.free_max = tbl_size[i];
			end
		end
		r.n_alloc = allocs_ok;
		r.n_release = releases_ok;
		r.n_fail = allocs_bad;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [STAT_W-1:0] got,
			logic [STAT_W-1:0] want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// idle length: mostly zero or short, now and then long
	function automatic int idle_len(int long_max);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		if (r < 94) return $urandom_range(1, 4);
		return $urandom_range(20, long_max);
	endfunction

	// response side stall pattern
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			stall_left <= idle_len(300);
			rsp_stall <= ($urandom_range(0, 1) == 1) && !quiet;
		end
	end

	// compare every response transfer against the oldest expectation
	always @(posedge clk) begin
		alloc_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("response count", STAT_W'(1), STAT_W'(0));
			end else begin
				want = pending_rsp.pop_front();
				if (status != want.status)
					report_mismatch("status", STAT_W'(status), STAT_W'(want.status));
				if (new_handle != want.handle)
					report_mismatch("new_handle", STAT_W'(new_handle), STAT_W'(want.handle));
				if (block_start != want.start)
					report_mismatch("block_start", STAT_W'(block_start), STAT_W'(want.start));
				if (free_total != want.free_sum)
					report_mismatch("free_total", STAT_W'(free_total),
						STAT_W'(want.free_sum));
				if (largest_free != want.free_max)
					report_mismatch("largest_free", STAT_W'(largest_free),
						STAT_W'(want.free_max));
				if (alloc_count != want.n_alloc)
					report_mismatch("alloc_count", alloc_count, want.n_alloc);
				if (release_count != want.n_release)
					report_mismatch("release_count", release_count, want.n_release);
				if (failure_count != want.n_fail)
					report_mismatch("failure_count", failure_count, want.n_fail);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// one command transfer; the expectation is formed when it is accepted
	task automatic send_cmd(logic op, logic [ADDR_W-1:0] req, logic [HDL_W-1:0] hdl,
			bit typed = 0, status_t st = ST_OK, logic [HDL_W-1:0] h = '0,
			logic [ADDR_W-1:0] s = '0);
		alloc_rsp_t r;
		int gap;
		cmd_valid <= 1'b1;
		cmd <= op;
		request_size <= req;
		release_handle <= hdl;
		do @(posedge clk); while (cmd_stall);
		r = predict_alloc(op, req, hdl);
		// typed rows override the predicted status, handle and start
		if (typed) begin
			r.status = st;
			r.handle = h;
			r.start = s;
		end
		pending_rsp.insert(pending_rsp.size(), r);
		gap = idle_len(60);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// sender goes idle until every expected result has come
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	// register write, only with nothing in flight
	task automatic write_reg(logic idx, logic [15:0] val);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_FIT_POLICY) begin
			cur_policy = policy_t'(val[1:0]);
		end else begin
			region_size = val;
			rebuild_region();
		end
	endtask

	// directed rows from reset: first fit over 65535 units
	cmd_row_t dir_rows [17] = '{
		'{CMD_ALLOC, 16'd0,     16'd0,     1'b1, ST_NO_FIT,    16'd0, 16'd0},
		'{CMD_ALLOC, 16'd65535, 16'd0,     1'b1, ST_OK,        16'd1, 16'd0},
		'{CMD_ALLOC, 16'd1,     16'd0,     1'b1, ST_NO_FIT,    16'd0, 16'd0},
		'{CMD_FREE,  16'd0,     16'd0,     1'b1, ST_NOT_FOUND, 16'd0, 16'd0},
		'{CMD_FREE,  16'd0,     16'd1,     1'b1, ST_OK,        16'd0, 16'd0},
		'{CMD_FREE,  16'd0,     16'd1,     1'b1, ST_NOT_FOUND, 16'd0, 16'd0},
		'{CMD_ALLOC, 16'd100,   16'd0,     1'b1, ST_OK,        16'd2, 16'd0},
		'{CMD_ALLOC, 16'd200,   16'd0,     1'b1, ST_OK,        16'd3, 16'd100},
		'{CMD_ALLOC, 16'd50,    16'd0,     1'b1, ST_OK,        16'd4, 16'd300},
		'{CMD_ALLOC, 16'd65185, 16'd0,     1'b1, ST_OK,        16'd5, 16'd350},
		'{CMD_FREE,  16'd0,     16'd2,     1'b0, ST_OK,        16'd0, 16'd0},
		'{CMD_FREE,  16'd0,     16'd4,     1'b0, ST_OK,        16'd0, 16'd0},
		'{CMD_FREE,  16'd0,     16'd3,     1'b0, ST_OK,        16'd0, 16'd0},
		'{CMD_FREE,  16'd0,     16'd65535, 1'b1, ST_NOT_FOUND, 16'd0, 16'd0},
		'{CMD_FREE,  16'd0,     16'd5,     1'b0, ST_OK,        16'd0, 16'd0},
		'{CMD_ALLOC, 16'd65535, 16'd0,     1'b1, ST_OK,        16'd6, 16'd0},
		'{CMD_FREE,  16'd0,     16'd6,     1'b0, ST_OK,        16'd0, 16'd0}
	};

	// random phase plan: policy, region size and item count
	policy_t pol_list [8] = '{POL_FIRST, POL_BEST, POL_WORST, POL_SPARE,
		POL_BEST, POL_FIRST, POL_WORST, POL_BEST};
	int size_list [8] = '{65535, 1000, 65535, 300, 1, 0, 5000, 65535};
	int item_list [8] = '{150, 200, 150, 120, 60, 20, 170, 160};

	initial begin
		int r, cap;
		logic [ADDR_W-1:0] req;
		logic [HDL_W-1:0] hdl;

		// shadow state after reset
		cur_policy = POL_FIRST;
		region_size = 16'hFFFF;
		handle_ctr = '0;
		allocs_ok = '0;
		releases_ok = '0;
		allocs_bad = '0;
		rebuild_region();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_cmd(dir_rows[i].op, dir_rows[i].size, dir_rows[i].hdl, dir_rows[i].typed,
				dir_rows[i].st, dir_rows[i].h, dir_rows[i].s);

		// random phases, each under its own policy and region size
		foreach (pol_list[ph]) begin
			write_reg(REG_FIT_POLICY, 16'(pol_list[ph]));
			write_reg(REG_TOTAL_SIZE, 16'(size_list[ph]));
			quiet = (ph == 2);
			cap = (size_list[ph] >> 4) > 1 ? (size_list[ph] >> 4) : 1;
			for (int n = 0; n < item_list[ph]; n++) begin
				// hold off mid-phase until the block has caught up
				if (ph == 1 && n == 100) wait_drained();
				r = $urandom_range(0, 99);
				if (r < 55) begin
					if (r < 2) req = '0;
					else if (r < 8) req = 16'($urandom());
					else req = 16'($urandom_range(1, cap));
					send_cmd(CMD_ALLOC, req, 16'($urandom()));
				end else begin
					if (live_handles.size() != 0 && r < 92)
						hdl = live_handles[$urandom_range(0, live_handles.size() - 1)];
					else if (r < 96)
						hdl = handle_ctr;
					else
						hdl = 16'($urandom());
					send_cmd(CMD_FREE, 16'($urandom()), hdl);
				end
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: sim.f
rtl/fac_pkg.sv
rtl/fac_cell.sv
rtl/free_list_fit_allocator.sv
dv/free_list_fit_allocator_tb.sv
